[rtl/lzwc12_pkg.sv]
// shared types and constants for the 12-bit lzw compressor
// no dependencies; used by lzw_compressor_12bit_top and lzwc12_checker
package lzwc12_pkg;

  // dictionary size in codes, 512 .. 4096
  localparam int unsigned DICT_ENTRIES = 4096;

  localparam int unsigned CODE_W     = 12;
  localparam int unsigned NEXT_W     = 13;
  localparam int unsigned KEY_W      = 20;
  localparam int unsigned FIRST_CODE = 256;
  localparam int unsigned DICT_AW    = $clog2(DICT_ENTRIES);
  // hash table is a power of two at least twice the dictionary
  localparam int unsigned HASH_AW    = DICT_AW + 1;
  localparam int unsigned HASH_DEPTH = 2 ** HASH_AW;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // hash slot: pair key and the code it was given
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } h_entry_t;

  // dictionary entry: pair key and the hash slot that owns the code
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [HASH_AW-1:0] slot;
  } d_entry_t;

endpackage

[rtl/lzw_compressor_12bit_top.sv]
// lzw compressor, fixed 12-bit codes packed big-endian two codes per three bytes
// depends on lzwc12_pkg (types, sizes)
//
// usage:
//   in channel  : in_valid/in_ready/in_item, one raw byte per item, last_byte marks
//                 the final byte of a stream
//   out channel : out_valid/out_ready/out_item, one packed byte per item, run_last
//                 set on the final byte caused by one input item (0 to 4 bytes)
// lookup:
//   the first byte of a stream needs no lookup
//   every other byte is looked up in an open-addressed hash table; one probe is a
//   hash table read followed by a dictionary read (1 or 2 probes on average,
//   table at most half full)
//   one item is in flight at a time; in_ready is high only while waiting for one
// output:
//   result bytes sit in a four-byte output buffer and leave one per cycle while
//   out_ready is high; the next item is accepted and searched while the buffer
//   drains, and waits at its final step only if it has bytes and the buffer is busy
// reset:
//   synchronous, active low; clears prefix, code counter, nibble state and the
//   output buffer. neither memory is cleared: a hash slot counts only if its code
//   is below the next free code and the dictionary entry of that code points back
//   to the slot with the same key, so stale contents are never taken as live
// end of stream: after flush and pad, prefix, code counter and nibble state are reset
module lzw_compressor_12bit_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lzwc12_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lzwc12_pkg::out_item_t out_item
);

  // controller states
  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for an item
  localparam logic [1:0] S_PROBE = 2'd1;  // hash slot read back, dictionary read issued
  localparam logic [1:0] S_CHECK = 2'd2;  // dictionary entry read back, slot judged
  localparam logic [1:0] S_FIN   = 2'd3;  // emit bytes, update prefix

  // outcome of the lookup
  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_MISS  = 2'd2;

  localparam logic [lzwc12_pkg::NEXT_W-1:0] FIRST_NEXT =
    lzwc12_pkg::NEXT_W'(lzwc12_pkg::FIRST_CODE);
  localparam logic [lzwc12_pkg::NEXT_W-1:0] LIMIT_NEXT =
    lzwc12_pkg::NEXT_W'(lzwc12_pkg::DICT_ENTRIES);

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
    logic       half;
    logic [3:0] nib;
  } emit_t;

  // one code into the big-endian 12-bit stream
  function automatic emit_t emit_code(input logic half, input logic [3:0] nib,
                                      input logic [lzwc12_pkg::CODE_W-1:0] code);
    emit_t e;
    if (half) begin
      e.b0   = {nib, code[11:8]};
      e.b1   = code[7:0];
      e.two  = 1'b1;
      e.half = 1'b0;
      e.nib  = 4'h0;
    end else begin
      e.b0   = code[11:4];
      e.b1   = 8'h00;
      e.two  = 1'b0;
      e.half = 1'b1;
      e.nib  = code[3:0];
    end
    return e;
  endfunction

  // fold the 20-bit pair key into a slot number
  function automatic logic [lzwc12_pkg::HASH_AW-1:0] slot_of(
      input logic [lzwc12_pkg::KEY_W-1:0] k);
    return k[lzwc12_pkg::HASH_AW-1:0] ^
           k[lzwc12_pkg::KEY_W-1 -: lzwc12_pkg::HASH_AW];
  endfunction

  // memories
  lzwc12_pkg::h_entry_t hmem [lzwc12_pkg::HASH_DEPTH];
  lzwc12_pkg::d_entry_t dmem [lzwc12_pkg::DICT_ENTRIES];
  lzwc12_pkg::h_entry_t h_q;
  lzwc12_pkg::d_entry_t d_q;

  logic                               h_re, h_we, d_re, d_we;
  logic [lzwc12_pkg::HASH_AW-1:0]     h_raddr;
  logic [lzwc12_pkg::DICT_AW-1:0]     d_raddr;

  // control state
  logic [1:0]                         state_r, state_nxt;
  logic [lzwc12_pkg::CODE_W-1:0]      prefix_r, prefix_nxt;
  logic                               have_prefix_r, have_prefix_nxt;
  logic [lzwc12_pkg::NEXT_W-1:0]      next_code_r, next_code_nxt;
  logic                               pending_half_r, pending_half_nxt;
  logic [3:0]                         pending_nibble_r, pending_nibble_nxt;
  logic [2:0]                         ocnt_r, ocnt_nxt;

  // per-item working registers
  logic [7:0]                         byte_r, byte_nxt;
  logic                               last_r, last_nxt;
  logic [lzwc12_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [lzwc12_pkg::HASH_AW-1:0]     slot_r, slot_nxt;
  logic [1:0]                         kind_r, kind_nxt;
  logic [lzwc12_pkg::CODE_W-1:0]      hit_code_r, hit_code_nxt;
  logic                               in_range_r, in_range_nxt;
  logic [3:0][7:0]                    obuf_r, obuf_nxt;

  // final step
  logic [lzwc12_pkg::CODE_W-1:0]      new_prefix;
  emit_t                              e_miss, e_last;
  logic [3:0][7:0]                    fin_bytes;
  logic [2:0]                         fin_cnt;
  logic                               fin_half;
  logic [3:0]                         fin_nib;
  logic                               fin_go;

  logic                               slot_live, slot_hit, in_acc, out_acc;
  lzwc12_pkg::in_item_t               in_d;

  assign in_d     = in_item;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (ocnt_r != 3'd0);
  assign out_acc  = out_valid && out_ready;
  assign out_item.out_byte = obuf_r[0];
  assign out_item.run_last = (ocnt_r == 3'd1);

  // a slot is live only if its code is current and owned by this slot
  assign slot_live = in_range_r && (d_q.key == h_q.key) && (d_q.slot == slot_r);
  assign slot_hit  = slot_live && (h_q.key == key_r);

  // bytes of the final step: emitted prefix on a miss, then flush and pad at the end
  assign new_prefix = (kind_r == KIND_HIT) ? hit_code_r : {4'h0, byte_r};
  assign e_miss = emit_code(pending_half_r, pending_nibble_r, prefix_r);

  always_comb begin
    fin_bytes = '0;
    fin_cnt   = 3'd0;
    fin_half  = pending_half_r;
    fin_nib   = pending_nibble_r;
    if (kind_r == KIND_MISS) begin
      fin_bytes[0] = e_miss.b0;
      fin_bytes[1] = e_miss.b1;
      fin_cnt      = e_miss.two ? 3'd2 : 3'd1;
      fin_half     = e_miss.half;
      fin_nib      = e_miss.nib;
    end
    e_last = emit_code(fin_half, fin_nib, new_prefix);
    if (last_r) begin
      fin_bytes[fin_cnt[1:0]] = e_last.b0;
      fin_cnt = fin_cnt + 3'd1;
      if (e_last.two) begin
        fin_bytes[fin_cnt[1:0]] = e_last.b1;
        fin_cnt = fin_cnt + 3'd1;
      end
      if (e_last.half) begin
        fin_bytes[fin_cnt[1:0]] = {e_last.nib, 4'h0};
        fin_cnt = fin_cnt + 3'd1;
      end
    end
  end

  // the final step waits only when it has bytes and the buffer is still draining
  assign fin_go = (state_r == S_FIN) && ((ocnt_r == 3'd0) || (fin_cnt == 3'd0));

  // controller
  always_comb begin
    state_nxt          = state_r;
    prefix_nxt         = prefix_r;
    have_prefix_nxt    = have_prefix_r;
    next_code_nxt      = next_code_r;
    pending_half_nxt   = pending_half_r;
    pending_nibble_nxt = pending_nibble_r;
    byte_nxt           = byte_r;
    last_nxt           = last_r;
    key_nxt            = key_r;
    slot_nxt           = slot_r;
    kind_nxt           = kind_r;
    hit_code_nxt       = hit_code_r;
    in_range_nxt       = in_range_r;
    h_re               = 1'b0;
    h_we               = 1'b0;
    d_re               = 1'b0;
    d_we               = 1'b0;
    h_raddr            = slot_r;
    d_raddr            = h_q.code[lzwc12_pkg::DICT_AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          byte_nxt = in_d.data_byte;
          last_nxt = in_d.last_byte;
          if (!have_prefix_r) begin
            kind_nxt  = KIND_FIRST;
            state_nxt = S_FIN;
          end else begin
            key_nxt   = {prefix_r, in_d.data_byte};
            slot_nxt  = slot_of({prefix_r, in_d.data_byte});
            h_raddr   = slot_of({prefix_r, in_d.data_byte});
            h_re      = 1'b1;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        in_range_nxt = ({1'b0, h_q.code} >= FIRST_NEXT) && ({1'b0, h_q.code} < next_code_r);
        d_re         = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        if (slot_hit) begin
          kind_nxt     = KIND_HIT;
          hit_code_nxt = h_q.code;
          state_nxt    = S_FIN;
        end else if (slot_live) begin
          // linear probing to the next slot
          slot_nxt  = slot_r + 1'b1;
          h_raddr   = slot_r + 1'b1;
          h_re      = 1'b1;
          state_nxt = S_PROBE;
        end else begin
          // free slot: the pair is absent, insert it while there is room
          kind_nxt = KIND_MISS;
          if (next_code_r < LIMIT_NEXT) begin
            h_we          = 1'b1;
            d_we          = 1'b1;
            next_code_nxt = next_code_r + 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          if (last_r) begin
            prefix_nxt         = '0;
            have_prefix_nxt    = 1'b0;
            next_code_nxt      = FIRST_NEXT;
            pending_half_nxt   = 1'b0;
            pending_nibble_nxt = 4'h0;
          end else begin
            prefix_nxt         = new_prefix;
            have_prefix_nxt    = 1'b1;
            pending_half_nxt   = fin_half;
            pending_nibble_nxt = fin_nib;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output buffer: loaded only when empty, shifts one byte per accepted item
  always_comb begin
    obuf_nxt = obuf_r;
    ocnt_nxt = ocnt_r;
    if (fin_go && (fin_cnt != 3'd0)) begin
      obuf_nxt = fin_bytes;
      ocnt_nxt = fin_cnt;
    end else if (out_acc) begin
      obuf_nxt = obuf_r >> 8;
      ocnt_nxt = ocnt_r - 3'd1;
    end
  end

  // memories, registered read
  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[slot_r] <= '{key: key_r, code: next_code_r[lzwc12_pkg::CODE_W-1:0]};
    end
    if (h_re) begin
      h_q <= hmem[h_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[next_code_r[lzwc12_pkg::DICT_AW-1:0]] <= '{key: key_r, slot: slot_r};
    end
    if (d_re) begin
      d_q <= dmem[d_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      prefix_r         <= '0;
      have_prefix_r    <= 1'b0;
      next_code_r      <= FIRST_NEXT;
      pending_half_r   <= 1'b0;
      pending_nibble_r <= 4'h0;
      ocnt_r           <= 3'd0;
    end else begin
      state_r          <= state_nxt;
      prefix_r         <= prefix_nxt;
      have_prefix_r    <= have_prefix_nxt;
      next_code_r      <= next_code_nxt;
      pending_half_r   <= pending_half_nxt;
      pending_nibble_r <= pending_nibble_nxt;
      ocnt_r           <= ocnt_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    kind_r     <= kind_nxt;
    hit_code_r <= hit_code_nxt;
    in_range_r <= in_range_nxt;
    obuf_r     <= obuf_nxt;
  end

endmodule

[rtl/lzwc12_checker.sv]
// port-level checks for lzw_compressor_12bit_top, attached by bind
// depends on lzwc12_pkg (item types)
module lzwc12_props (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input lzwc12_pkg::in_item_t  in_item,
  input logic                  out_valid,
  input logic                  out_ready,
  input lzwc12_pkg::out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one item at a time: no accept in the cycle right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  // the buffer is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // the last byte of a burst empties the buffer
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_item.run_last |=> !out_valid)
    else $error("byte shown after end of burst");

endmodule

bind lzw_compressor_12bit_top lzwc12_props u_lzwc12_props (.*);
